// ===== src/vssc_pkg.sv =====
// ----------------------------------------------------------------------------
// vssc_pkg
// Types, register codes and helpers shared by the velocity setpoint shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package vssc_pkg;

	localparam int CMD_LIMIT = 1000;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE_UP       = 3'd0,
		REG_RATE_DOWN     = 3'd1,
		REG_GAP_ON        = 3'd2,
		REG_GAP_OFF       = 3'd3,
		REG_RELEASE_TICKS = 3'd4
	} cfg_reg_t;

	localparam logic [10:0] RATE_UP_RST       = 11'd10;
	localparam logic [10:0] RATE_DOWN_RST     = 11'd10;
	localparam logic [14:0] GAP_ON_RST        = 15'd200;
	localparam logic [14:0] GAP_OFF_RST       = 15'd100;
	localparam logic [15:0] RELEASE_TICKS_RST = 16'd50;

	typedef struct packed {
		logic signed [15:0] intent;
		logic signed [15:0] measured;
	} tick_t;

	typedef struct packed {
		logic signed [10:0] setpoint_out;
		logic signed [11:0] accel_out;
		logic               clamp_flag;
	} shape_t;

	typedef struct packed {
		logic [10:0] rate_up;
		logic [10:0] rate_down;
		logic [14:0] gap_on;
		logic [14:0] gap_off;
		logic [15:0] release_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [10:0] held_setpoint;
		logic               clamp_on;
		logic [15:0]        release_count;
	} state_t;

	// Saturate a wide signed value to the command range
	function automatic logic signed [10:0] limit_cmd(input logic signed [17:0] v);
		logic signed [17:0] hi;
		logic signed [17:0] lo;
		hi = 18'(CMD_LIMIT);
		lo = -18'(CMD_LIMIT);
		if (v > hi) begin
			return 11'(CMD_LIMIT);
		end else if (v < lo) begin
			return -11'(CMD_LIMIT);
		end else begin
			return v[10:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/vssc_cfg.sv =====
// ----------------------------------------------------------------------------
// vssc_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module vssc_cfg
	import vssc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_up       <= RATE_UP_RST;
			cfg_q.rate_down     <= RATE_DOWN_RST;
			cfg_q.gap_on        <= GAP_ON_RST;
			cfg_q.gap_off       <= GAP_OFF_RST;
			cfg_q.release_ticks <= RELEASE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATE_UP:       cfg_q.rate_up       <= cfg_wdata[10:0];
				REG_RATE_DOWN:     cfg_q.rate_down     <= cfg_wdata[10:0];
				REG_GAP_ON:        cfg_q.gap_on        <= cfg_wdata[14:0];
				REG_GAP_OFF:       cfg_q.gap_off       <= cfg_wdata[14:0];
				REG_RELEASE_TICKS: cfg_q.release_ticks <= cfg_wdata;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/vssc_core.sv =====
// ----------------------------------------------------------------------------
// vssc_core
// One tick of slew limiting, slip gap hysteresis and slip clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module vssc_core
	import vssc_pkg::*;
(
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	input  wire tick_t  tick,
	output state_t      nxt,
	output shape_t      shape
);

	logic signed [10:0] target;
	logic signed [10:0] prev;
	logic signed [11:0] delta;
	logic signed [11:0] neg_delta;
	logic [10:0]        step_up;
	logic [10:0]        step_dn;
	logic signed [10:0] slewed;
	logic signed [15:0] gap;
	logic [15:0]        mag;
	logic [15:0]        cnt_inc;
	logic [15:0]        cnt_sat;
	logic [14:0]        lim;
	logic signed [16:0] neg_lim;
	logic signed [17:0] meas_hi;
	logic signed [17:0] meas_lo;
	logic               flag;
	logic [15:0]        count;
	logic signed [10:0] final_sp;

	assign target  = limit_cmd({{2{tick.intent[15]}}, tick.intent});
	assign prev    = cur.held_setpoint;
	assign delta   = {target[10], target} - {prev[10], prev};
	assign neg_delta = -delta;
	assign step_up = (cfg.rate_up == '0) ? 11'd1 : cfg.rate_up;
	assign step_dn = (cfg.rate_down == '0) ? 11'd1 : cfg.rate_down;

	// Slew: move toward target by at most one step
	always_comb begin
		slewed = prev;
		if (!delta[11] && delta != '0) begin
			if ($signed({delta[11], delta}) > $signed({2'b00, step_up})) begin
				slewed = 11'({prev[10], prev} + {1'b0, step_up});
			end else begin
				slewed = target;
			end
		end else if (delta[11]) begin
			if ($signed({neg_delta[11], neg_delta}) > $signed({2'b00, step_dn})) begin
				slewed = 11'({prev[10], prev} - {1'b0, step_dn});
			end else begin
				slewed = target;
			end
		end
	end

	assign gap = {{5{slewed[10]}}, slewed} - tick.measured;
	assign mag = gap[15] ? (~gap + 16'd1) : gap;

	assign cnt_inc = cur.release_count + 16'd1;
	assign cnt_sat = (cnt_inc > cfg.release_ticks) ? cfg.release_ticks : cnt_inc;

	// Hysteresis flag and release counter
	always_comb begin
		flag  = cur.clamp_on;
		count = cur.release_count;
		if (!cur.clamp_on) begin
			if (mag > {1'b0, cfg.gap_on}) begin
				flag  = 1'b1;
				count = '0;
			end
		end else if (mag <= {1'b0, cfg.gap_off}) begin
			count = cnt_sat;
			if (cnt_sat >= cfg.release_ticks) begin
				flag  = 1'b0;
				count = '0;
			end
		end else begin
			count = '0;
		end
	end

	assign lim     = (cfg.gap_on > cfg.gap_off) ? cfg.gap_on : cfg.gap_off;
	assign neg_lim = -$signed({2'b00, lim});
	assign meas_hi = {{2{tick.measured[15]}}, tick.measured} + {3'b000, lim};
	assign meas_lo = {{2{tick.measured[15]}}, tick.measured} - {3'b000, lim};

	// Slip clamp: keep setpoint within the band around measured
	always_comb begin
		final_sp = slewed;
		if (flag) begin
			if (gap > $signed({1'b0, lim})) begin
				final_sp = limit_cmd(meas_hi);
			end else if ($signed({gap[15], gap}) < neg_lim) begin
				final_sp = limit_cmd(meas_lo);
			end
		end
	end

	assign nxt.held_setpoint = final_sp;
	assign nxt.clamp_on      = flag;
	assign nxt.release_count = count;

	assign shape.setpoint_out = final_sp;
	assign shape.accel_out    = {final_sp[10], final_sp} - {prev[10], prev};
	assign shape.clamp_flag   = flag;

endmodule

`default_nettype wire

// ===== src/velocity_setpoint_slew_slip_clamp.sv =====
// ----------------------------------------------------------------------------
// velocity_setpoint_slew_slip_clamp
// Velocity setpoint shaper: slew limiter with a hysteresis slip clamp.
// ----------------------------------------------------------------------------
// Each item on the tick channel carries a velocity intent and a measured
// velocity; each yields exactly one item on the shape channel with the new
// setpoint, its change and the clamp flag. An item is taken into an input
// register, worked by combinational logic against the held state, and
// placed in the result register, so the block takes one item per clock
// while the shape channel does not stall. The state update of one item
// feeds the next directly, which lets the block keep that rate.
// Configuration registers may be written only while no item is in flight.
`default_nettype none

module velocity_setpoint_slew_slip_clamp
	import vssc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tick_valid,
	output logic                       tick_stall,
	input  wire tick_t                 tick_data,
	output logic                       shape_valid,
	input  wire logic                  shape_stall,
	output shape_t                     shape_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t   cfg;
	tick_t  tick_s1;
	logic   valid_s1;
	shape_t shape_s2;
	logic   valid_s2;
	state_t state_q;
	state_t state_nxt;
	shape_t shape_nxt;
	logic   out_free;
	logic   adv_s1;
	logic   take;

	vssc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	vssc_core u_core (
		.cfg   (cfg),
		.cur   (state_q),
		.tick  (tick_s1),
		.nxt   (state_nxt),
		.shape (shape_nxt)
	);

	assign out_free   = !valid_s2 || !shape_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign tick_stall = valid_s1 && !out_free;
	assign take       = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tick_s1 <= tick_data;
		end
		if (adv_s1) begin
			shape_s2 <= shape_nxt;
		end
	end

	assign shape_valid = valid_s2;
	assign shape_data  = shape_s2;

	// Held state mirrors the last result shown
	a_held_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (state_q.held_setpoint == shape_s2.setpoint_out &&
			state_q.clamp_on == shape_s2.clamp_flag))
		else $error("held state differs from result register");

	a_setpoint_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (shape_s2.setpoint_out <= 11'sd1000 &&
			shape_s2.setpoint_out >= -11'sd1000))
		else $error("setpoint out of command range");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with free pipeline");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("state changed without an item");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the velocity setpoint shaper (slew and slip clamp).
// ----------------------------------------------------------------------------
// A directed table covers reset values, field extremes, zero rates, the
// most negative slip gap, release counting and ignored register writes.
// Random phases follow, each with fresh register settings and one of four
// mixes of sender gaps and receiver stalls. One phase holds the result
// side off for a long stretch. Every result is compared field by field
// against a table value or a local shaper model run on each accepted tick.
// ----------------------------------------------------------------------------

module testbench;
	import vssc_pkg::*;

	localparam int PLAN_LEN = 32;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam tick_t TICK_ZERO = '0;
	localparam shape_t NO_WANT = '0;

	typedef struct {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [15:0]          reg_val;
		tick_t                stim;
		logic                 typed;
		shape_t               want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  tick_valid;
	logic                  tick_stall;
	tick_t                 tick_data;
	logic                  shape_valid;
	logic                  shape_stall;
	shape_t                shape_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Model state and register copies
	logic signed [10:0] held_sp;
	logic               clamp_st;
	logic [15:0]        rel_cnt;
	logic [10:0]        up_rate;
	logic [10:0]        dn_rate;
	logic [14:0]        on_gap;
	logic [14:0]        off_gap;
	logic [15:0]        rel_ticks;

	shape_t shaped_q[$];
	int     mism;
	int     cycle_cnt;
	int     idle_pct;
	int     stall_pct;
	int     hold_left;

	velocity_setpoint_slew_slip_clamp dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick_data  (tick_data),
		.shape_valid(shape_valid),
		.shape_stall(shape_stall),
		.shape_data (shape_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic int clip_cmd(input int v);
		if (v > CMD_LIMIT) return CMD_LIMIT;
		if (v < -CMD_LIMIT) return -CMD_LIMIT;
		return v;
	endfunction

	// Advance the model by one tick and return the shaped result
	task automatic shape_tick(input tick_t t, output shape_t r);
		int                 target;
		int                 meas;
		int                 prev;
		int                 shaped;
		int                 delta;
		int                 step;
		int                 gap;
		int                 mag;
		int                 lim;
		logic signed [15:0] gap16;
		logic [15:0]        cnt;
		logic               flag;
		target = clip_cmd(int'(t.intent));
		meas = int'(t.measured);
		prev = int'(held_sp);
		shaped = prev;
		delta = target - prev;
		flag = clamp_st;
		if (delta > 0) begin
			step = (up_rate == 11'd0) ? 1 : int'(up_rate);
			shaped = (delta > step) ? prev + step : target;
		end else if (delta < 0) begin
			step = (dn_rate == 11'd0) ? 1 : int'(dn_rate);
			shaped = (-delta > step) ? prev - step : target;
		end
		gap16 = 16'(shaped - meas);
		gap = int'(gap16);
		mag = (gap < 0) ? -gap : gap;
		if (!flag) begin
			if (mag > int'(on_gap)) begin
				flag = 1'b1;
				rel_cnt = 16'd0;
			end
		end else if (mag <= int'(off_gap)) begin
			cnt = rel_cnt + 16'd1;
			if (cnt > rel_ticks)
				cnt = rel_ticks;
			rel_cnt = cnt;
			if (rel_cnt >= rel_ticks) begin
				flag = 1'b0;
				rel_cnt = 16'd0;
			end
		end else begin
			rel_cnt = 16'd0;
		end
		if (flag) begin
			lim = (on_gap > off_gap) ? int'(on_gap) : int'(off_gap);
			if (gap > lim)
				shaped = clip_cmd(meas + lim);
			else if (gap < -lim)
				shaped = clip_cmd(meas - lim);
		end
		clamp_st = flag;
		r.setpoint_out = 11'(shaped);
		r.accel_out = 12'(shaped - prev);
		r.clamp_flag = flag;
		held_sp = 11'(shaped);
	endtask

	// Offer one item, called and returning at a falling edge
	task automatic send_tick(input tick_t t, input logic typed, input shape_t want);
		shape_t pred;
		while ($urandom_range(99) < idle_pct) begin
			tick_valid <= 1'b0;
			@(negedge clk);
		end
		tick_valid <= 1'b1;
		tick_data <= t;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		shape_tick(t, pred);
		shaped_q.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_RATE_UP:       up_rate = val[10:0];
			REG_RATE_DOWN:     dn_rate = val[10:0];
			REG_GAP_ON:        on_gap = val[14:0];
			REG_GAP_OFF:       off_gap = val[14:0];
			REG_RELEASE_TICKS: rel_ticks = val;
			default: ;
		endcase
	endtask

	// Drop valid and wait until every result is back and the pipe is empty
	task automatic settle();
		tick_valid <= 1'b0;
		while (shaped_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Result side: random stalls, or a counted hold-off when asked
	initial begin
		shape_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				shape_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				shape_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		shape_t exp_r;
		if (arst_n && shape_valid && !shape_stall) begin
			if (shaped_q.size() == 0) begin
				$display("%0t unexpected result: setpoint %0d accel %0d flag %0b", $time,
					shape_data.setpoint_out, shape_data.accel_out, shape_data.clamp_flag);
				mism++;
			end else begin
				exp_r = shaped_q.pop_front();
				if (shape_data.setpoint_out !== exp_r.setpoint_out) begin
					$display("%0t setpoint_out: expected %0d actual %0d", $time,
						exp_r.setpoint_out, shape_data.setpoint_out);
					mism++;
				end
				if (shape_data.accel_out !== exp_r.accel_out) begin
					$display("%0t accel_out: expected %0d actual %0d", $time,
						exp_r.accel_out, shape_data.accel_out);
					mism++;
				end
				if (shape_data.clamp_flag !== exp_r.clamp_flag) begin
					$display("%0t clamp_flag: expected %0b actual %0b", $time,
						exp_r.clamp_flag, shape_data.clamp_flag);
					mism++;
				end
			end
		end
	end

	initial begin : main
		plan_row_t   plan [PLAN_LEN];
		tick_t       t;
		logic [15:0] v;
		int          k;
		int          w;
		int          base;

		plan = '{
			'{1'b0, REG_RATE_UP, 16'h0, TICK_ZERO, 1'b1, '{11'sd0, 12'sd0, 1'b0}},
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sh7FFF, 16'sd0}, 1'b1,
				'{11'sd10, 12'sd10, 1'b0}},
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sh8000, 16'sd0}, 1'b1,
				'{11'sd0, -12'sd10, 1'b0}},
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sh8000, 16'sh7FFF}, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sd1000, 16'sd1000}, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, '{-16'sd1000, 16'sh7FFF}, 1'b0, NO_WANT},
			'{1'b1, REG_RELEASE_TICKS, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_RATE_UP, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_RATE_DOWN, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sd500, 16'sd0}, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, '{-16'sd500, 16'sd0}, 1'b0, NO_WANT},
			'{1'b1, REG_RATE_UP, 16'hFFFF, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_RATE_DOWN, 16'hFFFF, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_GAP_ON, 16'hFFFF, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_GAP_OFF, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			// gap of the most negative value engages even at the top threshold
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sd0, 16'sh8000}, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sd0, 16'sh8000}, 1'b0, NO_WANT},
			'{1'b1, REG_SPARE_LO, 16'h1234, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_SPARE_HI, 16'hFFFF, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_GAP_ON, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_GAP_OFF, 16'hFFFF, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_RELEASE_TICKS, 16'hFFFF, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sd1000, -16'sd1000}, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, '{16'sh7FFF, 16'sh8000}, 1'b0, NO_WANT},
			'{1'b1, REG_GAP_ON, 16'd200, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_GAP_OFF, 16'd100, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b1, REG_RELEASE_TICKS, 16'd2, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, TICK_ZERO, 1'b0, NO_WANT},
			'{1'b0, REG_RATE_UP, 16'h0, TICK_ZERO, 1'b0, NO_WANT}
		};

		mism = 0;
		cycle_cnt = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		arst_n = 1'b0;
		tick_valid = 1'b0;
		tick_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		held_sp = '0;
		clamp_st = 1'b0;
		rel_cnt = '0;
		up_rate = RATE_UP_RST;
		dn_rate = RATE_DOWN_RST;
		on_gap = GAP_ON_RST;
		off_gap = GAP_OFF_RST;
		rel_ticks = RELEASE_TICKS_RST;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_tick(plan[i].stim, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case ($urandom_range(3))
				0: v = 16'd0;
				1: v = 16'hFFFF;
				default: v = 16'($urandom_range(1, 60));
			endcase
			write_reg(REG_RATE_UP, v);
			case ($urandom_range(3))
				0: v = 16'd0;
				1: v = 16'($urandom);
				default: v = 16'($urandom_range(1, 60));
			endcase
			write_reg(REG_RATE_DOWN, v);
			case ($urandom_range(3))
				0: v = 16'd0;
				1: v = 16'h7FFF;
				default: v = 16'($urandom_range(50, 600));
			endcase
			write_reg(REG_GAP_ON, v);
			case ($urandom_range(3))
				0: v = 16'd0;
				1: v = 16'($urandom);
				default: v = 16'($urandom_range(10, 300));
			endcase
			write_reg(REG_GAP_OFF, v);
			case ($urandom_range(3))
				0: v = 16'd0;
				1: v = 16'hFFFF;
				default: v = 16'($urandom_range(1, 20));
			endcase
			write_reg(REG_RELEASE_TICKS, v);

			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 77;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 77;
				end
				default: begin
					idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			// hold the result side off so the block backs up into its input
			if (ph == 4)
				hold_left = 400;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				k = $urandom_range(99);
				base = int'(held_sp);
				if (k < 55) begin
					// track the setpoint so release counting gets exercised
					w = ($urandom_range(2) == 0) ? 400 : (($urandom_range(1) == 0) ? 150 : 20);
					t.intent = 16'(base + int'($urandom_range(0, 600)) - 300);
					t.measured = 16'(base + int'($urandom_range(0, 2 * w)) - w);
				end else if (k < 85) begin
					t.intent = 16'(int'($urandom_range(0, 2400)) - 1200);
					t.measured = 16'(int'($urandom_range(0, 3000)) - 1500);
				end else begin
					t.intent = 16'($urandom);
					t.measured = 16'($urandom);
				end
				send_tick(t, 1'b0, NO_WANT);
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mism == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
